>>> rtl/mode7_texture_address_gen_defines.svh
// Assertion macros for the floor-plane texture address generator checks.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MODE7_TEXTURE_ADDRESS_GEN_DEFINES_SVH
`define MODE7_TEXTURE_ADDRESS_GEN_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define M7TAG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("m7tag: same-cycle property violated");

// Check a consequent in the cycle after its antecedent
`define M7TAG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("m7tag: next-cycle property violated");

`endif

>>> rtl/m7tag_pkg.sv
// Types and constants of the floor-plane texture address generator.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none

package m7tag_pkg;

  // Map geometry
  localparam int MAP_SIZE  = 1024;
  localparam int TILE_SIZE = 8;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Pipeline shape: eight arithmetic stages, then one stage per quotient bit
  localparam int DIV_STEPS  = 16;
  localparam int NUM_STAGES = 8 + DIV_STEPS;

  // Saturation limits of the coordinates
  localparam logic [15:0] QUO_NEG_LIMIT = 16'd32768;
  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;

  // Register reset values
  localparam logic signed [20:0] CAM_H_RST      = 21'sd80768;
  localparam logic signed [20:0] CAM_V_RST      = 21'sd206848;
  localparam logic signed [20:0] PIVOT_X_RST    = 21'sd113536;
  localparam logic signed [20:0] PIVOT_Y_RST    = 21'sd235520;
  localparam logic signed [15:0] DIR_X_RST      = -16'sd16384;
  localparam logic signed [15:0] DIR_Y_RST      = 16'sd0;
  localparam logic [15:0]        DEPTH_GAIN_RST = 16'd4571;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_CAM_H      = 3'd0,
    REG_CAM_V      = 3'd1,
    REG_PIVOT_X    = 3'd2,
    REG_PIVOT_Y    = 3'd3,
    REG_DIR_X      = 3'd4,
    REG_DIR_Y      = 3'd5,
    REG_DEPTH_GAIN = 3'd6
  } reg_e;

  // One axis in the restoring divider
  typedef struct packed {
    logic [23:0] rem;
    logic [15:0] quo;
    logic        neg;
    logic        sat;
  } div_t;

  // One finished result
  typedef struct packed {
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic               inside_map;
    logic [2:0]         tile_x;
    logic [2:0]         tile_y;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/m7tag_pix_if.sv
// Pixel request channel: valid/ready handshake carrying a row and a column.
// No dependencies.
`default_nettype none

interface m7tag_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] row;
  logic [7:0] col;

  modport source (output valid, output row, output col, input ready);
  modport sink   (input valid, input row, input col, output ready);
endinterface

`default_nettype wire

>>> rtl/m7tag_tex_if.sv
// Texture address result channel: valid/ready handshake with map coordinates.
// No dependencies.
`default_nettype none

interface m7tag_tex_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] map_x;
  logic signed [15:0] map_y;
  logic               inside_map;
  logic [2:0]         tile_x;
  logic [2:0]         tile_y;

  modport source (output valid, output map_x, output map_y, output inside_map,
                  output tile_x, output tile_y, input ready);
  modport sink   (input valid, input map_x, input map_y, input inside_map,
                  input tile_x, input tile_y, output ready);
endinterface

`default_nettype wire

>>> rtl/mode7_texture_address_gen.sv
// Path from the edge that accepts a request to its result on tex_o:
// eight arithmetic stages (the first loads at the accepting edge), a restoring
// divider by row+1 that retires one quotient bit per stage (16 stages), then
// the output register. Throughput: one request per cycle; pix_i.ready drops
// only while the skid register holds a result behind a stalled output register.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// Depends on m7tag_pkg, m7tag_pix_if and m7tag_tex_if.
`default_nettype none

module mode7_texture_address_gen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  m7tag_pix_if.sink                       pix_i,
  m7tag_tex_if.source                     tex_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [m7tag_pkg::APB_AW-1:0]    paddr,
  input  logic [m7tag_pkg::APB_DW-1:0]    pwdata,
  output logic [m7tag_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  localparam int NS = m7tag_pkg::NUM_STAGES;
  localparam int DS = m7tag_pkg::DIV_STEPS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [20:0] cam_h_q, cam_v_q, pivot_x_q, pivot_y_q;
  logic signed [15:0] dir_x_q, dir_y_q;
  logic [15:0]        gain_q;
  logic               cfg_we;
  m7tag_pkg::reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = m7tag_pkg::reg_e'(paddr[4:2]);

  // Write a register at the access phase of an APB write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_h_q   <= m7tag_pkg::CAM_H_RST;
      cam_v_q   <= m7tag_pkg::CAM_V_RST;
      pivot_x_q <= m7tag_pkg::PIVOT_X_RST;
      pivot_y_q <= m7tag_pkg::PIVOT_Y_RST;
      dir_x_q   <= m7tag_pkg::DIR_X_RST;
      dir_y_q   <= m7tag_pkg::DIR_Y_RST;
      gain_q    <= m7tag_pkg::DEPTH_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        m7tag_pkg::REG_CAM_H:      cam_h_q   <= pwdata[20:0];
        m7tag_pkg::REG_CAM_V:      cam_v_q   <= pwdata[20:0];
        m7tag_pkg::REG_PIVOT_X:    pivot_x_q <= pwdata[20:0];
        m7tag_pkg::REG_PIVOT_Y:    pivot_y_q <= pwdata[20:0];
        m7tag_pkg::REG_DIR_X:      dir_x_q   <= pwdata[15:0];
        m7tag_pkg::REG_DIR_Y:      dir_y_q   <= pwdata[15:0];
        m7tag_pkg::REG_DEPTH_GAIN: gain_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      m7tag_pkg::REG_CAM_H:      prdata = {11'd0, cam_h_q};
      m7tag_pkg::REG_CAM_V:      prdata = {11'd0, cam_v_q};
      m7tag_pkg::REG_PIVOT_X:    prdata = {11'd0, pivot_x_q};
      m7tag_pkg::REG_PIVOT_Y:    prdata = {11'd0, pivot_y_q};
      m7tag_pkg::REG_DIR_X:      prdata = {16'd0, dir_x_q};
      m7tag_pkg::REG_DIR_Y:      prdata = {16'd0, dir_y_q};
      m7tag_pkg::REG_DEPTH_GAIN: prdata = {16'd0, gain_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the skid is full
  // ---------------------------------------------------------------------------
  logic [NS-1:0]     v_q;
  logic              en;
  logic              ov_q, ov_d, sv_q, sv_d;
  logic              out_ok;
  logic              ld_out_pipe, ld_out_skid, ld_skid;
  m7tag_pkg::res_t   res, out_q, skid_q;

  assign en          = ~sv_q;
  assign pix_i.ready = en;
  assign out_ok      = ~ov_q | tex_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], pix_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic stages
  // ---------------------------------------------------------------------------
  logic [8:0]         r1_q [NS-1];
  logic signed [22:0] p_d, q_d, p_q, q_q;
  logic signed [38:0] dyp_q, dxq_q, dyq_q, dxp_q;
  logic signed [39:0] sx_q, sy_q;
  logic [35:0]        tlo_x_q, tlo_y_q;
  logic signed [36:0] thi_x_q, thi_y_q;
  logic signed [56:0] t_x_q, t_y_q;
  logic signed [30:0] pr_x_q, pr_y_q;
  logic signed [56:0] nx_x, nx_y;
  logic signed [26:0] u_x_q, u_y_q;
  logic [27:0]        m_x_q, m_y_q;
  logic               neg_x_q, neg_y_q;

  // Offsets from the pivot in Q.8
  assign p_d = $signed({{2{cam_h_q[20]}}, cam_h_q}) - $signed({{2{pivot_x_q[20]}}, pivot_x_q})
             + $signed({7'd0, pix_i.col, 8'd0});
  assign q_d = $signed({7'd0, pix_i.row, 8'd0}) + $signed({{2{cam_v_q[20]}}, cam_v_q})
             - $signed({{2{pivot_y_q[20]}}, pivot_y_q});

  // Full numerators; dropping the low 30 bits floors by 2^30
  assign nx_x = t_x_q + (pr_x_q <<< 22);
  assign nx_y = t_y_q + (pr_y_q <<< 22);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 0: offsets and divisor
      p_q      <= p_d;
      q_q      <= q_d;
      r1_q[0]  <= {1'b0, pix_i.row} + 9'd1;
      for (int k = 1; k < NS - 1; k++) begin
        r1_q[k] <= r1_q[k-1];
      end
      // Stage 1: rotate by the view direction
      dyp_q    <= dir_y_q * p_q;
      dxq_q    <= dir_x_q * q_q;
      dyq_q    <= dir_y_q * q_q;
      dxp_q    <= dir_x_q * p_q;
      // Stage 2: combine the rotated terms
      sx_q     <= dyp_q + dxq_q;
      sy_q     <= dyq_q - dxp_q;
      // Stage 3: depth gain, split into two narrow partial products
      tlo_x_q  <= gain_q * sx_q[19:0];
      thi_x_q  <= $signed({1'b0, gain_q}) * $signed(sx_q[39:20]);
      tlo_y_q  <= gain_q * sy_q[19:0];
      thi_y_q  <= $signed({1'b0, gain_q}) * $signed(sy_q[39:20]);
      // Stage 4: merge partial products; scale the pivot by row+1
      t_x_q    <= (thi_x_q <<< 20) + $signed({21'd0, tlo_x_q});
      t_y_q    <= (thi_y_q <<< 20) + $signed({21'd0, tlo_y_q});
      pr_x_q   <= pivot_x_q * $signed({1'b0, r1_q[3]});
      pr_y_q   <= pivot_y_q * $signed({1'b0, r1_q[3]});
      // Stage 5: add the pivot and floor by 2^30
      u_x_q    <= nx_x[56:30];
      u_y_q    <= nx_y[56:30];
      // Stage 6: magnitude for a floored division; ~u + r1 = |u| + r1 - 1
      neg_x_q  <= u_x_q[26];
      neg_y_q  <= u_y_q[26];
      m_x_q    <= u_x_q[26] ? ({1'b0, ~u_x_q} + {19'd0, r1_q[5]}) : {1'b0, u_x_q};
      m_y_q    <= u_y_q[26] ? ({1'b0, ~u_y_q} + {19'd0, r1_q[5]}) : {1'b0, u_y_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider by row+1, one quotient bit per stage
  // ---------------------------------------------------------------------------
  m7tag_pkg::div_t div_x_q [DS+1];
  m7tag_pkg::div_t div_y_q [DS+1];

  function automatic m7tag_pkg::div_t div_step(m7tag_pkg::div_t cur, logic [23:0] dsr);
    m7tag_pkg::div_t nxt;
    logic            ge;
    nxt = cur;
    ge  = (cur.rem >= dsr);
    if (ge) begin
      nxt.rem = cur.rem - dsr;
    end
    nxt.quo = {cur.quo[14:0], ge};
    return nxt;
  endfunction

  // Stage 7: load the divider; a quotient of 2^16 or more saturates
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_x_q[0] <= '{rem: m_x_q[23:0], quo: '0, neg: neg_x_q,
                      sat: (m_x_q >= {3'd0, r1_q[6], 16'd0})};
      div_y_q[0] <= '{rem: m_y_q[23:0], quo: '0, neg: neg_y_q,
                      sat: (m_y_q >= {3'd0, r1_q[6], 16'd0})};
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [23:0] dsr;
    assign dsr = {15'd0, r1_q[7+j]} << (DS - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_x_q[j+1] <= div_step(div_x_q[j], dsr);
        div_y_q[j+1] <= div_step(div_y_q[j], dsr);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result: saturate, test the map bounds, derive tile coordinates
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] to_coord(m7tag_pkg::div_t d);
    logic signed [15:0] c;
    if (d.neg) begin
      if (d.sat || d.quo > m7tag_pkg::QUO_NEG_LIMIT) c = m7tag_pkg::COORD_MIN;
      else c = $signed(16'd0 - d.quo);
    end else begin
      if (d.sat || d.quo[15]) c = m7tag_pkg::COORD_MAX;
      else c = $signed(d.quo);
    end
    return c;
  endfunction

  function automatic logic [2:0] tile_of(logic signed [15:0] c);
    logic [15:0] mag;
    mag = c[15] ? (16'd0 - c) : c;
    return 3'(mag & 16'(m7tag_pkg::TILE_SIZE - 1));
  endfunction

  always_comb begin
    res.map_x      = to_coord(div_x_q[DS]);
    res.map_y      = to_coord(div_y_q[DS]);
    res.inside_map = (res.map_x > 0) && (res.map_x < $signed(16'(m7tag_pkg::MAP_SIZE))) &&
                     (res.map_y > 0) && (res.map_y < $signed(16'(m7tag_pkg::MAP_SIZE)));
    res.tile_x     = res.inside_map ? 3'd0 : tile_of(res.map_x);
    res.tile_y     = res.inside_map ? 3'd0 : tile_of(res.map_y);
  end

  // ---------------------------------------------------------------------------
  // Output register with a skid stage behind it
  // ---------------------------------------------------------------------------
  always_comb begin
    ov_d        = ov_q;
    sv_d        = sv_q;
    ld_out_pipe = 1'b0;
    ld_out_skid = 1'b0;
    ld_skid     = 1'b0;
    if (sv_q) begin
      // Drain the skid first
      if (out_ok) begin
        ov_d        = 1'b1;
        sv_d        = 1'b0;
        ld_out_skid = 1'b1;
      end
    end else if (out_ok) begin
      ov_d        = v_q[NS-1];
      ld_out_pipe = v_q[NS-1];
    end else if (v_q[NS-1]) begin
      // Park the result while the output stalls
      sv_d    = 1'b1;
      ld_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out_skid) begin
      out_q <= skid_q;
    end else if (ld_out_pipe) begin
      out_q <= res;
    end
    if (ld_skid) begin
      skid_q <= res;
    end
  end

  assign tex_o.valid      = ov_q;
  assign tex_o.map_x      = out_q.map_x;
  assign tex_o.map_y      = out_q.map_y;
  assign tex_o.inside_map = out_q.inside_map;
  assign tex_o.tile_x     = out_q.tile_x;
  assign tex_o.tile_y     = out_q.tile_y;

endmodule

`default_nettype wire

>>> rtl/m7tag_checker.sv
// Port-level checks of the floor-plane texture address generator, bound to it.
// Depends on m7tag_pkg and mode7_texture_address_gen_defines.svh.
`default_nettype none
`include "mode7_texture_address_gen_defines.svh"

module m7tag_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         tex_valid_i,
  input logic                         tex_ready_i,
  input logic signed [15:0]           map_x_i,
  input logic signed [15:0]           map_y_i,
  input logic                         inside_map_i,
  input logic [2:0]                   tile_x_i,
  input logic [2:0]                   tile_y_i,
  input logic                         psel_i,
  input logic                         penable_i,
  input logic                         pwrite_i,
  input logic                         pready_i,
  input logic [m7tag_pkg::APB_AW-1:0] paddr_i,
  input logic [m7tag_pkg::APB_DW-1:0] pwdata_i,
  input logic [m7tag_pkg::APB_DW-1:0] prdata_i
);

  // Hold a stalled result
  `M7TAG_ASSERT_NEXT(a_tex_valid_hold, tex_valid_i && !tex_ready_i, tex_valid_i)
  `M7TAG_ASSERT_NEXT(a_tex_data_hold, tex_valid_i && !tex_ready_i, $stable({map_x_i, map_y_i, inside_map_i, tile_x_i, tile_y_i}))

  // Inside the map: coordinates in range and no tile pattern
  `M7TAG_ASSERT_NOW(a_inside_consistent, tex_valid_i && inside_map_i, tile_x_i == 3'd0 && tile_y_i == 3'd0 && map_x_i > 0 && map_y_i > 0 && map_x_i < $signed(16'(m7tag_pkg::MAP_SIZE)) && map_y_i < $signed(16'(m7tag_pkg::MAP_SIZE)))

  // Read back a camera offset just written
  `M7TAG_ASSERT_NEXT(a_cam_h_readback, psel_i && penable_i && pwrite_i && pready_i && paddr_i[4:2] == m7tag_pkg::REG_CAM_H, paddr_i != $past(paddr_i) || prdata_i[20:0] == $past(pwdata_i[20:0]))

endmodule

bind mode7_texture_address_gen m7tag_checker u_m7tag_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tex_valid_i  (tex_o.valid),
  .tex_ready_i  (tex_o.ready),
  .map_x_i      (tex_o.map_x),
  .map_y_i      (tex_o.map_y),
  .inside_map_i (tex_o.inside_map),
  .tile_x_i     (tex_o.tile_x),
  .tile_y_i     (tex_o.tile_y),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .pready_i     (pready),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);

`default_nettype wire

>>> verif/tb_mode7_texture_address_gen.sv
// Self-checking testbench for the floor-plane texture address generator.
// Depends on m7tag_pkg, m7tag_pix_if, m7tag_tex_if and mode7_texture_address_gen.
// A directed table runs first, then randomized register settings and pixel requests.
`default_nettype none

module tb_mode7_texture_address_gen;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 4;
  localparam int PIPE_LATENCY    = m7tag_pkg::NUM_STAGES;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int IDLE_PERCENT    = 29;
  localparam int NUM_REGS        = 7;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int QUIET_PHASE     = 6;
  localparam int HOLD_PHASE      = 2;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_e;
  typedef enum logic [1:0] {CFG_PLAUSIBLE, CFG_ANY, CFG_CORNER} cfg_style_e;

  typedef struct {
    step_kind_e kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic [7:0]  row;
    logic [7:0]  col;
    bit          typed;
    m7tag_pkg::res_t texel;
  } dir_step_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [m7tag_pkg::APB_AW-1:0] paddr;
  logic [m7tag_pkg::APB_DW-1:0] pwdata;
  logic [m7tag_pkg::APB_DW-1:0] prdata;
  logic pready;

  m7tag_pix_if pix_if ();
  m7tag_tex_if tex_if ();

  mode7_texture_address_gen dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .tex_o   (tex_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the projection registers
  logic signed [20:0] sh_cam_h;
  logic signed [20:0] sh_cam_v;
  logic signed [20:0] sh_pivot_x;
  logic signed [20:0] sh_pivot_y;
  logic signed [15:0] sh_dir_x;
  logic signed [15:0] sh_dir_y;
  logic [15:0]        sh_gain;

  m7tag_pkg::res_t pending_texels[$];
  dir_step_t steps[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Floor toward minus infinity
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return m7tag_pkg::COORD_MAX;
    if (v < -32768) return m7tag_pkg::COORD_MIN;
    return v[15:0];
  endfunction

  function automatic logic [2:0] tile_coord(logic signed [15:0] c);
    longint a;
    a = (c < 0) ? -longint'(c) : longint'(c);
    return 3'(a % m7tag_pkg::TILE_SIZE);
  endfunction

  // Project one pixel onto the map with the shadow registers, exact then floored
  function automatic m7tag_pkg::res_t texel_address(logic [7:0] row, logic [7:0] col);
    longint r1, p, q, den, nx, ny;
    logic signed [15:0] mx, my;
    m7tag_pkg::res_t r;
    r1  = longint'(row) + 1;
    p   = longint'(sh_cam_h) - longint'(sh_pivot_x) + 256 * longint'(col);
    q   = 256 * longint'(row) + longint'(sh_cam_v) - longint'(sh_pivot_y);
    den = r1 << 30;
    nx  = longint'(sh_pivot_x) * r1 * (longint'(1) << 22)
        + longint'(sh_gain) * (longint'(sh_dir_y) * p + longint'(sh_dir_x) * q);
    ny  = longint'(sh_pivot_y) * r1 * (longint'(1) << 22)
        + longint'(sh_gain) * (longint'(sh_dir_y) * q - longint'(sh_dir_x) * p);
    mx  = clamp16(floor_div(nx, den));
    my  = clamp16(floor_div(ny, den));
    r.map_x      = mx;
    r.map_y      = my;
    r.inside_map = (mx > 0) && (mx < m7tag_pkg::MAP_SIZE) &&
                   (my > 0) && (my < m7tag_pkg::MAP_SIZE);
    r.tile_x     = r.inside_map ? 3'd0 : tile_coord(mx);
    r.tile_y     = r.inside_map ? 3'd0 : tile_coord(my);
    return r;
  endfunction

  function automatic void add_write(logic [2:0] idx, logic [31:0] data);
    dir_step_t s;
    s = '{kind: STEP_WRITE, default: '0};
    s.reg_idx = idx;
    s.wdata   = data;
    steps.push_back(s);
  endfunction

  function automatic void add_pixel(logic [7:0] row, logic [7:0] col);
    dir_step_t s;
    s = '{kind: STEP_PIXEL, default: '0};
    s.row  = row;
    s.col  = col;
    steps.push_back(s);
  endfunction

  function automatic void add_checked_pixel(logic [7:0] row, logic [7:0] col, int mx, int my,
                                            logic in_map, logic [2:0] tx, logic [2:0] ty);
    dir_step_t s;
    s = '{kind: STEP_PIXEL, default: '0};
    s.row              = row;
    s.col              = col;
    s.typed            = 1'b1;
    s.texel.map_x      = 16'(mx);
    s.texel.map_y      = 16'(my);
    s.texel.inside_map = in_map;
    s.texel.tile_x     = tx;
    s.texel.tile_y     = ty;
    steps.push_back(s);
  endfunction

  // Compare one returned texel address with the oldest pending one
  task automatic compare_texel(m7tag_pkg::res_t got);
    m7tag_pkg::res_t want;
    if (pending_texels.size() == 0) begin
      $error("unexpected texel address: map_x %0d map_y %0d",
             $signed(got.map_x), $signed(got.map_y));
      error_count++;
    end else begin
      want = pending_texels.pop_front();
      if (got.map_x !== want.map_x) begin
        $error("map_x: expected %0d, got %0d", $signed(want.map_x), $signed(got.map_x));
        error_count++;
      end
      if (got.map_y !== want.map_y) begin
        $error("map_y: expected %0d, got %0d", $signed(want.map_y), $signed(got.map_y));
        error_count++;
      end
      if (got.inside_map !== want.inside_map) begin
        $error("inside_map: expected %0d, got %0d", want.inside_map, got.inside_map);
        error_count++;
      end
      if (got.tile_x !== want.tile_x) begin
        $error("tile_x: expected %0d, got %0d", want.tile_x, got.tile_x);
        error_count++;
      end
      if (got.tile_y !== want.tile_y) begin
        $error("tile_y: expected %0d, got %0d", want.tile_y, got.tile_y);
        error_count++;
      end
    end
  endtask

  // Sample accepted results, then pick the next ready level
  always @(posedge clk_i) begin
    m7tag_pkg::res_t got;
    if (rst_ni && tex_if.valid && tex_if.ready) begin
      got.map_x      = tex_if.map_x;
      got.map_y      = tex_if.map_y;
      got.inside_map = tex_if.inside_map;
      got.tile_x     = tex_if.tile_x;
      got.tile_y     = tex_if.tile_y;
      compare_texel(got);
    end
    tex_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one pixel request after random idle cycles, and hold until accepted
  task automatic send_pixel(logic [7:0] row, logic [7:0] col, bit typed,
                            m7tag_pkg::res_t typed_texel);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.row   <= row;
    pix_if.col   <= col;
    do @(posedge clk_i); while (!pix_if.ready);
    pending_texels.push_back(typed ? typed_texel : texel_address(row, col));
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
  endtask

  // Setup and access cycles, then update the shadow copy
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      m7tag_pkg::REG_CAM_H:      sh_cam_h   = data[20:0];
      m7tag_pkg::REG_CAM_V:      sh_cam_v   = data[20:0];
      m7tag_pkg::REG_PIVOT_X:    sh_pivot_x = data[20:0];
      m7tag_pkg::REG_PIVOT_Y:    sh_pivot_y = data[20:0];
      m7tag_pkg::REG_DIR_X:      sh_dir_x   = data[15:0];
      m7tag_pkg::REG_DIR_Y:      sh_dir_y   = data[15:0];
      m7tag_pkg::REG_DEPTH_GAIN: sh_gain    = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Load a fresh register set in one of three styles
  task automatic program_registers(cfg_style_e style);
    logic [31:0] v [NUM_REGS];
    logic [31:0] pos_corner [4];
    logic [31:0] dir_corner [5];
    logic [31:0] gain_corner [3];
    int dx, dy;
    pos_corner  = '{32'h000FFFFF, 32'h00100000, 32'h00000000, 32'hFFFFFFFF};
    dir_corner  = '{32'h00007FFF, 32'h00008000, 32'h00004000, 32'h0000C000, 32'h00000000};
    gain_corner = '{32'h00000000, 32'h00000001, 32'h0000FFFF};
    case (style)
      CFG_PLAUSIBLE: begin
        // Camera and pivot near the map, unit view direction, moderate gain
        v[m7tag_pkg::REG_CAM_H]   = $urandom_range(0, 327679) - 65536;
        v[m7tag_pkg::REG_CAM_V]   = $urandom_range(0, 327679) - 65536;
        v[m7tag_pkg::REG_PIVOT_X] = $urandom_range(0, 262143);
        v[m7tag_pkg::REG_PIVOT_Y] = $urandom_range(0, 262143);
        dx = int'($urandom_range(0, 32768)) - 16384;
        dy = int'($sqrt(real'(268435456 - dx * dx)));
        if ($urandom_range(1) == 1) dy = -dy;
        v[m7tag_pkg::REG_DIR_X]      = dx;
        v[m7tag_pkg::REG_DIR_Y]      = dy;
        v[m7tag_pkg::REG_DEPTH_GAIN] = $urandom_range(256, 16383);
      end
      CFG_ANY: begin
        for (int i = 0; i < NUM_REGS; i++) v[i] = $urandom;
      end
      default: begin
        v[m7tag_pkg::REG_CAM_H]      = pos_corner[$urandom_range(3)];
        v[m7tag_pkg::REG_CAM_V]      = pos_corner[$urandom_range(3)];
        v[m7tag_pkg::REG_PIVOT_X]    = pos_corner[$urandom_range(3)];
        v[m7tag_pkg::REG_PIVOT_Y]    = pos_corner[$urandom_range(3)];
        v[m7tag_pkg::REG_DIR_X]      = dir_corner[$urandom_range(4)];
        v[m7tag_pkg::REG_DIR_Y]      = dir_corner[$urandom_range(4)];
        v[m7tag_pkg::REG_DEPTH_GAIN] = gain_corner[$urandom_range(2)];
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), v[i]);
  endtask

  initial begin
    cfg_style_e style;
    logic [7:0] row;
    no_idle         = 1'b0;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.row      <= '0;
    pix_if.col      <= '0;
    sh_cam_h   = m7tag_pkg::CAM_H_RST;
    sh_cam_v   = m7tag_pkg::CAM_V_RST;
    sh_pivot_x = m7tag_pkg::PIVOT_X_RST;
    sh_pivot_y = m7tag_pkg::PIVOT_Y_RST;
    sh_dir_x   = m7tag_pkg::DIR_X_RST;
    sh_dir_y   = m7tag_pkg::DIR_Y_RST;
    sh_gain    = m7tag_pkg::DEPTH_GAIN_RST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults, including rows past the floor area
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd191, 8'd255);
    add_pixel(8'd255, 8'd255);
    add_pixel(8'd0, 8'd128);
    add_pixel(8'd100, 8'd17);
    // A write to an unmapped address leaves every register alone
    add_write(REG_UNMAPPED, 32'hFFFFFFFF);
    add_pixel(8'd0, 8'd0);
    // Zero gain: the map point is the pivot itself
    add_write(m7tag_pkg::REG_DEPTH_GAIN, 32'h0);
    add_write(m7tag_pkg::REG_PIVOT_X, 32'd25600);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'd51200);
    add_checked_pixel(8'd0, 8'd0, 100, 200, 1'b1, 3'd0, 3'd0);
    add_checked_pixel(8'd255, 8'd255, 100, 200, 1'b1, 3'd0, 3'd0);
    // Map edges are outside: zero and map size fail the strict test
    add_write(m7tag_pkg::REG_PIVOT_X, 32'd0);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'd261888);
    add_checked_pixel(8'd7, 8'd9, 0, 1023, 1'b0, 3'd0, 3'd7);
    add_write(m7tag_pkg::REG_PIVOT_X, 32'd256);
    add_checked_pixel(8'd7, 8'd9, 1, 1023, 1'b1, 3'd0, 3'd0);
    add_write(m7tag_pkg::REG_PIVOT_X, 32'd262144);
    add_checked_pixel(8'd7, 8'd9, 1024, 1023, 1'b0, 3'd0, 3'd7);
    // Negative fractions floor down, positive ones truncate
    add_write(m7tag_pkg::REG_PIVOT_X, 32'h001FFFFF);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'd255);
    add_checked_pixel(8'd3, 8'd4, -1, 0, 1'b0, 3'd1, 3'd0);
    add_write(m7tag_pkg::REG_PIVOT_X, 32'h00100000);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'h000FFFFF);
    add_checked_pixel(8'd3, 8'd4, -4096, 4095, 1'b0, 3'd0, 3'd7);
    // Coordinate overflow at full gain and oversized direction
    add_write(m7tag_pkg::REG_CAM_H, 32'h000FFFFF);
    add_write(m7tag_pkg::REG_CAM_V, 32'h000FFFFF);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'h00100000);
    add_write(m7tag_pkg::REG_DIR_X, 32'h00008000);
    add_write(m7tag_pkg::REG_DIR_Y, 32'h00008000);
    add_write(m7tag_pkg::REG_DEPTH_GAIN, 32'h0000FFFF);
    add_checked_pixel(8'd0, 8'd255, -32768, 32767, 1'b0, 3'd0, 3'd7);
    add_pixel(8'd255, 8'd0);
    add_pixel(8'd191, 8'd128);
    add_write(m7tag_pkg::REG_DIR_X, 32'h00007FFF);
    add_write(m7tag_pkg::REG_DIR_Y, 32'h00007FFF);
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd255, 8'd255);
    // Diagonal view direction, plain camera
    add_write(m7tag_pkg::REG_DIR_X, 32'h00004000);
    add_write(m7tag_pkg::REG_DIR_Y, 32'h0000C000);
    add_write(m7tag_pkg::REG_DEPTH_GAIN, 32'd256);
    add_write(m7tag_pkg::REG_CAM_H, 32'd0);
    add_write(m7tag_pkg::REG_CAM_V, 32'd0);
    add_write(m7tag_pkg::REG_PIVOT_X, 32'd131072);
    add_write(m7tag_pkg::REG_PIVOT_Y, 32'd131072);
    add_pixel(8'd10, 8'd20);

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_WRITE) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].wdata);
      end else begin
        send_pixel(steps[i].row, steps[i].col, steps[i].typed, steps[i].texel);
      end
    end

    // Random register sets, each followed by a burst of pixel requests
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        1:       style = CFG_ANY;
        3:       style = CFG_CORNER;
        default: style = CFG_PLAUSIBLE;
      endcase
      settle();
      program_registers(style);
      no_idle = (ph == QUIET_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off mid-burst until the pipeline has emptied
        if (ph == HOLD_PHASE && n == ITEMS_PER_PHASE / 2) settle();
        row = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 191))
                                        : 8'($urandom_range(192, 255));
        send_pixel(row, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    settle();
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> mode7_texture_address_gen.f
+incdir+rtl
rtl/m7tag_pkg.sv
rtl/m7tag_pix_if.sv
rtl/m7tag_tex_if.sv
rtl/mode7_texture_address_gen.sv
rtl/m7tag_checker.sv
verif/tb_mode7_texture_address_gen.sv
